@@ rtl/rle_byte_decoder_defines.svh @@
// Assertion macros used by the port-level checker of the RLE byte decoder.
`ifndef RLE_BYTE_DECODER_DEFINES_SVH
`define RLE_BYTE_DECODER_DEFINES_SVH

// Checked at every rising clock edge, reset included.
`define RBD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked outside reset only.
`define RBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ rtl/rbd_pkg.sv @@
// Shared types and constants of the RLE byte decoder.
package rbd_pkg;

    localparam int          HEADER_BYTES     = 8;
    localparam logic [2:0]  LAST_HEADER_IDX  = 3'(HEADER_BYTES - 1);
    localparam logic [6:0]  BYTES_PER_RESULT = 7'd2;
    localparam logic [7:0]  RUN_FLAG         = 8'h80;
    localparam logic [7:0]  RUN_MASK         = 8'h7F;
    localparam logic [7:0]  RAW_COPY_FLAG    = 8'h01;
    localparam logic [31:0] CAPACITY_RESET   = 32'd92228;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_RAW    = 3'd1,
        PH_BODY   = 3'd2,
        PH_DONE   = 3'd3,
        PH_ERROR  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        STS_PROGRESS  = 3'd0,
        STS_FINISHED  = 3'd1,
        STS_BAD_TAG   = 3'd2,
        STS_TOO_LARGE = 3'd3,
        STS_IGNORED   = 3'd4
    } status_t;

    typedef enum logic {
        CS_STEP = 1'b0,
        CS_FILL = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic load_step;   // decode the accepted byte, load first result beat
        logic load_fill;   // load next beat of a fill run
    } dp_cmd_t;

    typedef struct packed {
        logic step_multi;  // current byte yields more than one result beat
        logic fill_final;  // pending fill beat is the last one
    } dp_status_t;

endpackage

@@ rtl/rle_byte_decoder.sv @@
// The first result beat of a byte shows in the output register in the cycle after the byte is taken.
// Throughput: one byte per cycle while out_stall is low and each byte yields at most
// two decoded bytes; a fill run of n bytes holds the input for ceil(n/2)-1 further
// beats, set by the single output register draining two bytes per beat.
// Reset (rst_n low, async): decoder returns to header phase, no beat pending,
// capacity back to 92228.
module rle_byte_decoder
    import rbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // compressed byte input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        frame_start,
    input  logic [7:0]  in_byte,
    // decoded result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  first_byte,
    output logic [7:0]  second_byte,
    output logic [1:0]  byte_count,
    output logic        last,
    output logic [2:0]  status,
    // APB-style configuration port, capacity at address 0
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    // single register: every address decodes to capacity
    logic unused_addr;
    assign unused_addr = ^paddr;

    assign pready = 1'b1 | unused_addr;

    // Controller owns the handshake: it takes a byte whenever the output
    // beat is free (or leaves this cycle) and no fill run is draining.
    rbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Datapath decodes the byte in the cycle it is taken and loads the first
    // beat; later beats of a fill run come from the held byte and count.
    rbd_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .frame_start (frame_start),
        .in_byte     (in_byte),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .byte_count  (byte_count),
        .last        (last),
        .status      (status)
    );

endmodule

@@ rtl/rbd_ctrl.sv @@
// Controller FSM of the RLE byte decoder: input/output handshake and fill drain.
module rbd_ctrl
    import rbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t stat
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_STEP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_STEP:
            begin
                if (in_valid && out_free && stat.step_multi)
                    state_next = CS_FILL;
            end
            CS_FILL:
            begin
                if (out_free && stat.fill_final)
                    state_next = CS_STEP;
            end
            default: state_next = CS_STEP;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            CS_STEP:
            begin
                in_stall = !out_free;
                if (in_valid && out_free)
                begin
                    cmd.load_step  = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            CS_FILL:
            begin
                in_stall = 1'b1;
                if (out_free)
                begin
                    cmd.load_fill  = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: in_stall = 1'b1;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/rbd_datapath.sv @@
// Datapath of the RLE byte decoder: header parse, run state, capacity, result beat.
module rbd_datapath
    import rbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  stat,
    input  logic        frame_start,
    input  logic [7:0]  in_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic [7:0]  first_byte,
    output logic [7:0]  second_byte,
    output logic [1:0]  byte_count,
    output logic        last,
    output logic [2:0]  status
);

    // decoder state
    logic [31:0] capacity_reg;
    phase_t      phase_reg, phase_next;
    logic [2:0]  header_index_reg, header_index_next;
    logic [15:0] tag_word_reg, tag_word_next;
    logic        raw_mode_reg, raw_mode_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [6:0]  run_left_reg, run_left_next;
    logic        fill_pending_reg, fill_pending_next;

    // fill drain
    logic [7:0]  fill_byte_reg;
    logic [6:0]  fill_left_reg, fill_left_next;
    logic [2:0]  status_hold_reg;

    // result beat
    logic [7:0]  first_byte_reg, second_byte_reg;
    logic [1:0]  byte_count_reg;
    logic        last_reg;
    logic [2:0]  status_reg;

    // state after an optional restart
    phase_t      eff_phase;
    logic [2:0]  eff_index;
    logic [15:0] eff_tag;
    logic        eff_raw;
    logic [31:0] eff_left;
    logic [6:0]  eff_run;
    logic        eff_fill;

    status_t     step_status;
    logic [6:0]  step_n;
    logic [6:0]  fill_cnt;
    logic [1:0]  beat_cnt;

    assign eff_phase = frame_start ? PH_HEADER : phase_reg;
    assign eff_index = frame_start ? 3'd0      : header_index_reg;
    assign eff_tag   = frame_start ? 16'd0     : tag_word_reg;
    assign eff_raw   = frame_start ? 1'b0      : raw_mode_reg;
    assign eff_left  = frame_start ? 32'd0     : bytes_left_reg;
    assign eff_run   = frame_start ? 7'd0      : run_left_reg;
    assign eff_fill  = frame_start ? 1'b0      : fill_pending_reg;

    // fill length truncated at what is left of the decoded size
    assign fill_cnt = (eff_left < {25'd0, eff_run}) ? eff_left[6:0] : eff_run;

    always_comb
    begin
        phase_next        = eff_phase;
        header_index_next = eff_index;
        tag_word_next     = eff_tag;
        raw_mode_next     = eff_raw;
        bytes_left_next   = eff_left;
        run_left_next     = eff_run;
        fill_pending_next = eff_fill;
        step_status       = STS_PROGRESS;
        step_n            = 7'd0;
        case (eff_phase)
            PH_HEADER:
            begin
                case (eff_index)
                    3'd0: tag_word_next = {8'd0, in_byte};
                    3'd1: tag_word_next = {eff_tag[7:0], in_byte};
                    3'd3: raw_mode_next = |(in_byte & RAW_COPY_FLAG);
                    3'd4: bytes_left_next = {24'd0, in_byte};
                    default:
                    begin
                        if (eff_index inside {[3'd5:3'd7]})
                            bytes_left_next = {eff_left[23:0], in_byte};
                    end
                endcase
                header_index_next = eff_index + 3'd1;
                if (eff_index == LAST_HEADER_IDX)
                begin
                    if (eff_tag != 16'd0)
                    begin
                        phase_next  = PH_ERROR;
                        step_status = STS_BAD_TAG;
                    end
                    else if (bytes_left_next > capacity_reg)
                    begin
                        phase_next  = PH_ERROR;
                        step_status = STS_TOO_LARGE;
                    end
                    else if (bytes_left_next == 32'd0)
                    begin
                        phase_next  = PH_DONE;
                        step_status = STS_FINISHED;
                    end
                    else
                    begin
                        phase_next        = eff_raw ? PH_RAW : PH_BODY;
                        run_left_next     = 7'd0;
                        fill_pending_next = 1'b0;
                    end
                end
            end
            PH_RAW:
            begin
                step_n          = 7'd1;
                bytes_left_next = eff_left - 32'd1;
                if (bytes_left_next == 32'd0)
                begin
                    phase_next  = PH_DONE;
                    step_status = STS_FINISHED;
                end
            end
            PH_BODY:
            begin
                if (eff_fill)
                begin
                    step_n            = fill_cnt;
                    bytes_left_next   = eff_left - {25'd0, fill_cnt};
                    run_left_next     = 7'd0;
                    fill_pending_next = 1'b0;
                end
                else if (eff_run != 7'd0)
                begin
                    step_n          = 7'd1;
                    run_left_next   = eff_run - 7'd1;
                    bytes_left_next = eff_left - 32'd1;
                end
                else
                begin
                    run_left_next     = in_byte[6:0] & RUN_MASK[6:0];
                    fill_pending_next = |(in_byte & RUN_FLAG);
                end
                if (bytes_left_next == 32'd0)
                begin
                    phase_next        = PH_DONE;
                    step_status       = STS_FINISHED;
                    run_left_next     = 7'd0;
                    fill_pending_next = 1'b0;
                end
            end
            default: step_status = STS_IGNORED;
        endcase
    end

    assign stat.step_multi = step_n > BYTES_PER_RESULT;
    assign stat.fill_final = fill_left_reg <= BYTES_PER_RESULT;

    assign beat_cnt = (fill_left_reg >= BYTES_PER_RESULT) ? 2'd2 : fill_left_reg[1:0];

    always_comb
    begin
        fill_left_next = fill_left_reg;
        if (cmd.load_step)
            fill_left_next = stat.step_multi ? step_n - BYTES_PER_RESULT : 7'd0;
        else if (cmd.load_fill)
            fill_left_next = fill_left_reg - {5'd0, beat_cnt};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg     <= CAPACITY_RESET;
            phase_reg        <= PH_HEADER;
            header_index_reg <= 3'd0;
            tag_word_reg     <= 16'd0;
            raw_mode_reg     <= 1'b0;
            bytes_left_reg   <= 32'd0;
            run_left_reg     <= 7'd0;
            fill_pending_reg <= 1'b0;
            fill_left_reg    <= 7'd0;
        end
        else
        begin
            if (psel && penable && pwrite)
                capacity_reg <= pwdata;
            if (cmd.load_step)
            begin
                phase_reg        <= phase_next;
                header_index_reg <= header_index_next;
                tag_word_reg     <= tag_word_next;
                raw_mode_reg     <= raw_mode_next;
                bytes_left_reg   <= bytes_left_next;
                run_left_reg     <= run_left_next;
                fill_pending_reg <= fill_pending_next;
            end
            fill_left_reg <= fill_left_next;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_step)
        begin
            fill_byte_reg   <= in_byte;
            status_hold_reg <= step_status;
            first_byte_reg  <= (step_n != 7'd0) ? in_byte : 8'd0;
            second_byte_reg <= (step_n >= BYTES_PER_RESULT) ? in_byte : 8'd0;
            byte_count_reg  <= (step_n >= BYTES_PER_RESULT) ? 2'd2 : step_n[1:0];
            last_reg        <= !stat.step_multi;
            status_reg      <= step_status;
        end
        else if (cmd.load_fill)
        begin
            first_byte_reg  <= fill_byte_reg;
            second_byte_reg <= (beat_cnt == 2'd2) ? fill_byte_reg : 8'd0;
            byte_count_reg  <= beat_cnt;
            last_reg        <= stat.fill_final;
            status_reg      <= status_hold_reg;
        end
    end

    assign prdata      = capacity_reg;
    assign first_byte  = first_byte_reg;
    assign second_byte = second_byte_reg;
    assign byte_count  = byte_count_reg;
    assign last        = last_reg;
    assign status      = status_reg;

endmodule

@@ rtl/rbd_checker.sv @@
// Port-level checker of the RLE byte decoder and its bind.
`include "rle_byte_decoder_defines.svh"

module rbd_checker
    import rbd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic [7:0] first_byte,
    input logic [1:0] byte_count,
    input logic       last,
    input logic [2:0] status
);

    `RBD_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_n |-> !out_valid, "beat valid during reset")
    `RBD_ASSERT(a_count_range, out_valid |-> byte_count != 2'd3, "byte_count out of range")
    `RBD_ASSERT(a_run_holds_input, (out_valid && !last) |-> in_stall, "input taken mid run")
    `RBD_ASSERT(a_empty_is_last, (out_valid && byte_count == 2'd0) |-> last, "empty beat not last")
    `RBD_ASSERT(a_ignored_empty, (out_valid && status == STS_IGNORED) |-> (byte_count == 2'd0 && first_byte == 8'd0), "ignored byte produced data")

endmodule

bind rle_byte_decoder rbd_checker u_rbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .first_byte (first_byte),
    .byte_count (byte_count),
    .last       (last),
    .status     (status)
);

@@ dv/rle_byte_decoder_tb.sv @@
// Self-checking testbench for rle_byte_decoder: directed table, then random streams per capacity.
`timescale 1ns / 100ps

module rle_byte_decoder_tb;
    import rbd_pkg::*;

    // Timeout, counted in clocks, set well above the slowest legal run.
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam logic [1:0]  CAPACITY_ADDR = 2'd0;   // capacity is register 0
    localparam int          ITEMS_PER_CAP = 28;     // accepted (non-ignored) input bytes per phase
    localparam int          ERR_PRINT_MAX = 40;

    // One decoded result beat, in port order.
    typedef struct packed {
        logic [7:0] first_b;
        logic [7:0] second_b;
        logic [1:0] cnt;
        logic       fin;
        status_t    st;
    } decoded_beat_t;

    // Directed row. Where 'typed' is set, the expected beat is the single empty beat
    // {0, 0, count 0, last 1, want_st}; otherwise the predictor supplies it.
    typedef struct packed {
        logic       fs;
        logic [7:0] data;
        logic       typed;
        status_t    want_st;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        frame_start;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [1:0]  byte_count;
    logic        last;
    logic [2:0]  status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: a private copy of the decoder.
    phase_t      dec_phase;
    logic [2:0]  hdr_idx;
    logic [15:0] tag_acc;
    logic        raw_sel;
    logic [31:0] bytes_remaining;
    logic [6:0]  run_count;
    logic        fill_armed;
    logic [31:0] capacity_now;

    decoded_beat_t step_beats[$];     // beats caused by the byte just taken
    decoded_beat_t pending_beats[$];  // beats still owed by the DUT, oldest first

    int          err_count   = 0;
    int          coded_items = 0;     // accepted bytes that were not ignored
    int unsigned cycle_count = 0;
    int          stall_left  = 0;
    int          recv_roll;
    logic        calm = 1'b0;         // set: no idling on either side
    decoded_beat_t mon_got;
    decoded_beat_t mon_want;

    // Directed part. Stream A has no frame_start (decoder sits in the header phase after
    // reset): size 8, compressed; zero-length fill whose value byte is swallowed, zero-length
    // literal, one literal 0x00, then a 127 fill cut down to the 7 bytes left, which finishes.
    // A byte after done is ignored. Stream B is all 0xFF: tag is nonzero and the size is over
    // capacity, and the tag wins. A byte after the error is ignored.
    stim_row_t directed_rows [25] = '{
        {1'b0, 8'h00, 1'b1, STS_PROGRESS},
        {1'b0, 8'h00, 1'b1, STS_PROGRESS},
        {1'b0, 8'h00, 1'b1, STS_PROGRESS},
        {1'b0, 8'h00, 1'b1, STS_PROGRESS},
        {1'b0, 8'h00, 1'b1, STS_PROGRESS},
        {1'b0, 8'h00, 1'b1, STS_PROGRESS},
        {1'b0, 8'h00, 1'b1, STS_PROGRESS},
        {1'b0, 8'h08, 1'b1, STS_PROGRESS},
        {1'b0, 8'h80, 1'b1, STS_PROGRESS},
        {1'b0, 8'hFF, 1'b1, STS_PROGRESS},
        {1'b0, 8'h00, 1'b1, STS_PROGRESS},
        {1'b0, 8'h01, 1'b1, STS_PROGRESS},
        {1'b0, 8'h00, 1'b0, STS_PROGRESS},
        {1'b0, 8'hFF, 1'b1, STS_PROGRESS},
        {1'b0, 8'hFF, 1'b0, STS_PROGRESS},
        {1'b0, 8'h7F, 1'b1, STS_IGNORED},
        {1'b1, 8'hFF, 1'b1, STS_PROGRESS},
        {1'b0, 8'hFF, 1'b1, STS_PROGRESS},
        {1'b0, 8'hFF, 1'b1, STS_PROGRESS},
        {1'b0, 8'hFF, 1'b1, STS_PROGRESS},
        {1'b0, 8'hFF, 1'b1, STS_PROGRESS},
        {1'b0, 8'hFF, 1'b1, STS_PROGRESS},
        {1'b0, 8'hFF, 1'b1, STS_PROGRESS},
        {1'b0, 8'hFF, 1'b1, STS_BAD_TAG},
        {1'b0, 8'h00, 1'b1, STS_IGNORED}
    };

    rle_byte_decoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .frame_start (frame_start),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .byte_count  (byte_count),
        .last        (last),
        .status      (status),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= ERR_PRINT_MAX)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void restart_decoder();
        dec_phase       = PH_HEADER;
        hdr_idx         = 3'd0;
        tag_acc         = 16'h0000;
        raw_sel         = 1'b0;
        bytes_remaining = 32'd0;
        run_count       = 7'd0;
        fill_armed      = 1'b0;
    endfunction

    // Decodes one accepted byte and leaves the beats it causes in step_beats.
    function automatic void decode_byte(input logic fs, input logic [7:0] b);
        logic [7:0]    dec [128];
        int            n;
        int            nres;
        int            k;
        logic [31:0]   take;
        status_t       st;
        decoded_beat_t beat;

        n  = 0;
        st = STS_PROGRESS;
        step_beats.delete();
        if (fs)
            restart_decoder();

        case (dec_phase)
            PH_HEADER:
            begin
                // big-endian: tag[15:0], flags[15:0], size[31:0]; flags high byte unused
                case (hdr_idx)
                    3'd0: tag_acc = {8'h00, b};
                    3'd1: tag_acc = {tag_acc[7:0], b};
                    3'd3: raw_sel = (b & RAW_COPY_FLAG) != 8'h00;
                    3'd4: bytes_remaining = {24'h000000, b};
                    3'd5, 3'd6, 3'd7: bytes_remaining = {bytes_remaining[23:0], b};
                    default: ;
                endcase
                if (hdr_idx == LAST_HEADER_IDX)
                begin
                    if (tag_acc != 16'h0000)
                    begin
                        dec_phase = PH_ERROR;
                        st        = STS_BAD_TAG;
                    end
                    else if (bytes_remaining > capacity_now)
                    begin
                        dec_phase = PH_ERROR;
                        st        = STS_TOO_LARGE;
                    end
                    else if (bytes_remaining == 32'd0)
                    begin
                        dec_phase = PH_DONE;
                        st        = STS_FINISHED;
                    end
                    else
                    begin
                        dec_phase  = raw_sel ? PH_RAW : PH_BODY;
                        run_count  = 7'd0;
                        fill_armed = 1'b0;
                    end
                end
                hdr_idx = hdr_idx + 3'd1;
            end
            PH_RAW:
            begin
                dec[n] = b;
                n++;
                bytes_remaining--;
                if (bytes_remaining == 32'd0)
                begin
                    dec_phase = PH_DONE;
                    st        = STS_FINISHED;
                end
            end
            PH_BODY:
            begin
                if (fill_armed)
                begin
                    // fill value: emit the run, clipped to what the header still allows
                    take = ({25'd0, run_count} < bytes_remaining) ? {25'd0, run_count}
                                                                  : bytes_remaining;
                    for (k = 0; k < int'(take); k++)
                    begin
                        dec[n] = b;
                        n++;
                    end
                    bytes_remaining -= take;
                    run_count  = 7'd0;
                    fill_armed = 1'b0;
                end
                else if (run_count != 7'd0)
                begin
                    dec[n] = b;
                    n++;
                    run_count--;
                    bytes_remaining--;
                end
                else
                begin
                    run_count  = 7'(b & RUN_MASK);
                    fill_armed = (b & RUN_FLAG) != 8'h00;
                end
                if (bytes_remaining == 32'd0)
                begin
                    dec_phase  = PH_DONE;
                    st         = STS_FINISHED;
                    run_count  = 7'd0;
                    fill_armed = 1'b0;
                end
            end
            default: st = STS_IGNORED;   // done or error: byte dropped, state kept
        endcase

        // pack two decoded bytes per beat; a byte with no output still gets one empty beat
        nres = (n == 0) ? 1 : (n + 1) / 2;
        for (k = 0; k < nres; k++)
        begin
            beat.first_b  = (n > 2 * k)     ? dec[2 * k]     : 8'h00;
            beat.second_b = (n > 2 * k + 1) ? dec[2 * k + 1] : 8'h00;
            beat.cnt      = (n >= 2 * k + 2) ? 2'd2 : (n == 2 * k + 1) ? 2'd1 : 2'd0;
            beat.fin      = (k == nres - 1);
            beat.st       = st;
            step_beats.push_back(beat);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Mostly back-to-back, some short gaps, the odd long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Offers one byte, holds it until taken, then books the beats it owes.
    task automatic send_beat(input logic fs, input logic [7:0] data,
                             input logic typed = 1'b0, input status_t want_st = STS_PROGRESS);
        int            gap;
        decoded_beat_t want;

        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        frame_start <= fs;
        in_byte     <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);

        decode_byte(fs, data);
        if (typed)
        begin
            want = {8'h00, 8'h00, 2'd0, 1'b1, want_st};
            pending_beats.push_back(want);
        end
        else
        begin
            foreach (step_beats[k])
                pending_beats.push_back(step_beats[k]);
        end
        if (step_beats[0].st != STS_IGNORED)
            coded_items++;
    endtask

    // Drop valid and wait for every owed beat, then allow some slack.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One random stream: header, then a body that matches the header kind. Some bodies
    // are cut short (broken stream) and get restarted by the next frame_start.
    task automatic run_stream();
        logic [15:0] tag;
        logic [15:0] flags;
        logic [31:0] size;
        logic [31:0] made;
        logic [31:0] left;
        logic [63:0] hdr;
        int          kind;
        int          r;
        int          len;
        int          budget;
        int          sent;
        int          i;

        kind     = $urandom_range(0, 99);
        tag      = 16'h0000;
        size     = 32'd0;
        flags    = 16'($urandom);
        flags[0] = ($urandom_range(0, 3) == 0);   // raw copy now and then

        if (kind < 10 || (kind < 20 && capacity_now == 32'hFFFF_FFFF))
        begin
            tag  = 16'($urandom_range(1, 16'hFFFF));
            size = $urandom;
        end
        else if (kind < 20)
        begin
            // over capacity: right at the boundary or anywhere above it
            size = ($urandom_range(0, 1) == 0) ? capacity_now + 32'd1
                                               : $urandom_range(capacity_now + 1, 32'hFFFF_FFFF);
        end
        else if (kind < 26 || capacity_now == 32'd0)
        begin
            size = 32'd0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                size = capacity_now;
            else if (r < 13)
                size = $urandom_range(1, (capacity_now < 100) ? capacity_now : 100);
            else
                size = $urandom_range(1, (capacity_now < 40) ? capacity_now : 40);
        end

        budget = (size > 400 || $urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : 1000;

        hdr = {tag, flags, size};
        for (i = 0; i < 8; i++)
            send_beat(i == 0, hdr[63 - 8 * i -: 8]);

        if (tag == 16'h0000 && size != 32'd0 && size <= capacity_now)
        begin
            if (flags[0])
            begin
                for (i = 0; i < size && i < budget; i++)
                    send_beat(1'b0, 8'($urandom));
            end
            else
            begin
                made = 32'd0;
                sent = 0;
                while (made < size && sent < budget)
                begin
                    r    = $urandom_range(0, 99);
                    len  = (r < 80) ? $urandom_range(0, 8)
                         : (r < 95) ? $urandom_range(9, 40) : $urandom_range(41, 127);
                    left = size - made;
                    if ($urandom_range(0, 1) == 1)
                    begin
                        // fill run: control then value
                        send_beat(1'b0, RUN_FLAG | 8'(len));
                        send_beat(1'b0, 8'($urandom));
                        sent += 2;
                    end
                    else
                    begin
                        // literal run, usually kept within the size; overrun bytes get ignored
                        if (len > left && $urandom_range(0, 3) != 0)
                            len = int'(left);
                        send_beat(1'b0, 8'(len));
                        for (i = 0; i < len; i++)
                            send_beat(1'b0, 8'($urandom));
                        sent += 1 + len;
                    end
                    made += len;
                end
            end
        end

        // stray bytes without frame_start
        if ($urandom_range(0, 4) == 0)
        begin
            r = $urandom_range(1, 3);
            for (i = 0; i < r; i++)
                send_beat(1'b0, 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write capacity, read it back. Only called with the decoder drained.
    task automatic set_capacity(input logic [31:0] value);
        logic [31:0] rd;

        apb_xfer(1'b1, value, rd);
        capacity_now = value;
        apb_xfer(1'b0, 32'd0, rd);
        if (rd !== value)
            flag_error($sformatf("capacity readback %h, wrote %h", rd, value));
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    // Receiver pacing: random stall bursts, none while calm.
    always @(posedge clk)
    begin
        if (calm)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            recv_roll = $urandom_range(0, 99);
            if (recv_roll < 60)
                out_stall <= 1'b0;
            else if (recv_roll < 92)
            begin
                stall_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = $urandom_range(7, 29);
                out_stall <= 1'b1;
            end
        end
    end

    // Every taken beat must match the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            mon_got = {first_byte, second_byte, byte_count, last, status};
            if (pending_beats.size() == 0)
                flag_error($sformatf("unexpected beat %h %h n=%0d last=%0b st=%0d",
                                     first_byte, second_byte, byte_count, last, status));
            else
            begin
                mon_want = pending_beats.pop_front();
                if (mon_got !== mon_want)
                    flag_error($sformatf(
                        "beat %h %h n=%0d last=%0b st=%0d, want %h %h n=%0d last=%0b st=%0d",
                        mon_got.first_b, mon_got.second_b, mon_got.cnt, mon_got.fin,
                        mon_got.st, mon_want.first_b, mon_want.second_b, mon_want.cnt,
                        mon_want.fin, mon_want.st));
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [31:0] cap_plan [5];
        int          target;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        frame_start <= 1'b0;
        in_byte     <= 8'h00;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= CAPACITY_ADDR;
        pwdata      <= 32'd0;
        capacity_now = CAPACITY_RESET;
        restart_decoder();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows run against the reset capacity
        foreach (directed_rows[i])
            send_beat(directed_rows[i].fs, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].want_st);
        wait_drained();

        // capacity sweep: both extremes, a small value, the reset value, a random one
        cap_plan[0] = 32'd0;
        cap_plan[1] = 32'hFFFF_FFFF;
        cap_plan[2] = 32'd37;
        cap_plan[3] = CAPACITY_RESET;
        cap_plan[4] = $urandom_range(1, 300);
        target      = coded_items;
        foreach (cap_plan[p])
        begin
            set_capacity(cap_plan[p]);
            calm   = (p == 2);       // one phase at full rate on both sides
            target = target + ITEMS_PER_CAP;
            while (coded_items < target)
                run_stream();
            wait_drained();          // sender holds off until every owed beat is in
            calm = 1'b0;
        end

        repeat (6) @(posedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
